@@ rtl/core/psp_pkg.sv @@
// shared types and constants of the pat section parser
`default_nettype none

package psp_pkg;

   // section framing
   localparam logic [11:0] MIN_LENGTH       = 12'd9;
   localparam logic [11:0] HEADER_AFTER_LEN = 12'd5;
   localparam logic [11:0] CRC_BYTES        = 12'd4;
   localparam logic [7:0]  LEN_HI_MASK      = 8'h0F;

   // result kinds
   localparam logic [1:0] KIND_PROGRAM = 2'd0;
   localparam logic [1:0] KIND_NETWORK = 2'd1;
   localparam logic [1:0] KIND_SUMMARY = 2'd2;
   localparam logic [1:0] KIND_BADLEN  = 2'd3;

   // token queue between front and back, depth a power of two
   localparam int PSP_QDEPTH = 4;
   localparam int PSP_QAW    = $clog2(PSP_QDEPTH);

   typedef struct packed {
      logic [7:0] section_byte;
      logic       section_start;
   } psp_req_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [15:0] prog_num;
      logic [12:0] pid_value;
      logic [7:0]  table_ident;
      logic [15:0] stream_ident;
      logic [4:0]  version_field;
      logic        current_flag;
      logic [7:0]  section_index;
      logic [7:0]  last_section_index;
      logic [31:0] crc_value;
      logic [9:0]  entry_count;
      logic        section_done;
   } psp_rsp_type;

   // what the back end does with one byte
   typedef enum logic [3:0] {
      OP_START,
      OP_BADLEN,
      OP_STREAM_HI,
      OP_STREAM_LO,
      OP_VERSION,
      OP_SECT,
      OP_LAST_SECT,
      OP_ENTRY,
      OP_ENTRY_END,
      OP_CRC,
      OP_CRC_LAST
   } psp_op_type;

   typedef struct packed {
      psp_op_type op;
      logic [7:0] data;
   } psp_token_type;

endpackage

`default_nettype wire

@@ rtl/core/psp_front.sv @@
// front end: tracks section position and classifies each byte
`default_nettype none

module psp_front
   import psp_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire psp_req_type   req_beat,
   output logic               tok_valid,
   input  wire logic          tok_ready,
   output psp_token_type      tok
);

   typedef enum logic [1:0] {
      LEN_HI,
      LEN_LO,
      LEN_KNOWN
   } len_stage_type;

   logic          active_ff, active_in;
   len_stage_type stage_ff, stage_in;
   logic [11:0]   len_ff, len_in;
   logic [11:0]   pos_ff, pos_in;
   logic          accept;
   logic [11:0]   len_full;

   assign req_ready = tok_ready;
   assign accept    = req_valid && tok_ready;
   assign len_full  = len_ff | {4'd0, req_beat.section_byte};

   always_comb begin
      active_in = active_ff;
      stage_in  = stage_ff;
      len_in    = len_ff;
      pos_in    = pos_ff;
      tok_valid = 1'b0;
      tok.op    = OP_START;
      tok.data  = req_beat.section_byte;
      if (accept) begin
         if (req_beat.section_start) begin
            active_in = 1'b1;
            stage_in  = LEN_HI;
            len_in    = 12'd0;
            pos_in    = 12'd0;
            tok_valid = 1'b1;
            tok.op    = OP_START;
         end else if (active_ff) begin
            if (stage_ff == LEN_HI) begin
               len_in   = {req_beat.section_byte[3:0] & LEN_HI_MASK[3:0], 8'd0};
               stage_in = LEN_LO;
            end else if (stage_ff == LEN_LO) begin
               len_in   = len_full;
               stage_in = LEN_KNOWN;
               pos_in   = 12'd0;
               if (len_full < MIN_LENGTH) begin
                  active_in = 1'b0;
                  tok_valid = 1'b1;
                  tok.op    = OP_BADLEN;
               end
            end else begin
               pos_in    = pos_ff + 12'd1;
               tok_valid = 1'b1;
               if (pos_ff < HEADER_AFTER_LEN) begin
                  case (pos_ff[2:0])
                     3'd0:    tok.op = OP_STREAM_HI;
                     3'd1:    tok.op = OP_STREAM_LO;
                     3'd2:    tok.op = OP_VERSION;
                     3'd3:    tok.op = OP_SECT;
                     default: tok.op = OP_LAST_SECT;
                  endcase
               end else if (pos_ff < len_ff - CRC_BYTES) begin
                  // fourth entry byte falls on positions that are multiples of four
                  tok.op = (pos_ff[1:0] == 2'd0) ? OP_ENTRY_END : OP_ENTRY;
               end else if (pos_ff == len_ff - 12'd1) begin
                  tok.op    = OP_CRC_LAST;
                  active_in = 1'b0;
               end else begin
                  tok.op = OP_CRC;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         stage_ff  <= LEN_HI;
         len_ff    <= 12'd0;
         pos_ff    <= 12'd0;
      end else begin
         active_ff <= active_in;
         stage_ff  <= stage_in;
         len_ff    <= len_in;
         pos_ff    <= pos_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/psp_queue.sv @@
// short token queue between front and back end
`default_nettype none

module psp_queue
   import psp_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push_valid,
   output logic               push_ready,
   input  wire psp_token_type push_tok,
   output logic               pop_valid,
   input  wire logic          pop_ready,
   output psp_token_type      pop_tok
);

   psp_token_type              mem_ff [PSP_QDEPTH];
   logic [PSP_QAW-1:0]         wr_ptr_ff, rd_ptr_ff;
   logic [PSP_QAW:0]           count_ff;
   logic                       do_push, do_pop;

   assign push_ready = (count_ff != (PSP_QAW+1)'(PSP_QDEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_tok    = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_tok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/psp_back.sv @@
// back end: header capture, entry assembly, crc capture and result register
`default_nettype none

module psp_back
   import psp_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          tok_valid,
   output logic               tok_ready,
   input  wire psp_token_type tok,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output psp_rsp_type        rsp_beat
);

   logic [7:0]  table_ff;
   logic [15:0] stream_ff;
   logic [4:0]  version_ff;
   logic        current_ff;
   logic [7:0]  sect_ff;
   logic [7:0]  last_ff;
   logic [23:0] entry_ff;
   logic [31:0] crc_ff;
   logic [9:0]  tally_ff;
   logic        rsp_valid_ff;
   psp_rsp_type rsp_ff, rsp_in;

   logic        makes_rsp, slot_free, do_pop, load_rsp;
   logic [15:0] prog;
   logic [9:0]  tally_next;
   logic [31:0] crc_next;

   assign makes_rsp  = (tok.op == OP_BADLEN) || (tok.op == OP_ENTRY_END) ||
                       (tok.op == OP_CRC_LAST);
   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign tok_ready  = !makes_rsp || slot_free;
   assign do_pop     = tok_valid && tok_ready;
   assign load_rsp   = do_pop && makes_rsp;
   assign prog       = entry_ff[23:8];
   assign tally_next = tally_ff + 10'd1;
   assign crc_next   = {crc_ff[23:0], tok.data};

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_beat   = rsp_ff;

   always_comb begin
      rsp_in                    = '0;
      rsp_in.table_ident        = table_ff;
      rsp_in.stream_ident       = stream_ff;
      rsp_in.version_field      = version_ff;
      rsp_in.current_flag       = current_ff;
      rsp_in.section_index      = sect_ff;
      rsp_in.last_section_index = last_ff;
      rsp_in.entry_count        = tally_ff;
      case (tok.op)
         OP_BADLEN: begin
            rsp_in.result_kind  = KIND_BADLEN;
            rsp_in.section_done = 1'b1;
         end
         OP_ENTRY_END: begin
            rsp_in.pid_value = {entry_ff[4:0], tok.data};
            if (prog == 16'd0) begin
               rsp_in.result_kind = KIND_NETWORK;
            end else begin
               rsp_in.result_kind = KIND_PROGRAM;
               rsp_in.prog_num    = prog;
               rsp_in.entry_count = tally_next;
            end
         end
         default: begin
            rsp_in.result_kind  = KIND_SUMMARY;
            rsp_in.crc_value    = crc_next;
            rsp_in.section_done = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_pop) begin
         case (tok.op)
            OP_START: begin
               table_ff   <= tok.data;
               stream_ff  <= 16'd0;
               version_ff <= 5'd0;
               current_ff <= 1'b0;
               sect_ff    <= 8'd0;
               last_ff    <= 8'd0;
               entry_ff   <= 24'd0;
               crc_ff     <= 32'd0;
               tally_ff   <= 10'd0;
            end
            OP_STREAM_HI: stream_ff <= {tok.data, 8'd0};
            OP_STREAM_LO: stream_ff <= {stream_ff[15:8], tok.data};
            OP_VERSION: begin
               version_ff <= tok.data[5:1];
               current_ff <= tok.data[0];
            end
            OP_SECT: begin
               sect_ff <= tok.data;
               last_ff <= 8'd0;
            end
            OP_LAST_SECT: last_ff  <= tok.data;
            OP_ENTRY:     entry_ff <= {entry_ff[15:0], tok.data};
            OP_ENTRY_END: begin
               entry_ff <= 24'd0;
               if (prog != 16'd0) begin
                  tally_ff <= tally_next;
               end
            end
            OP_CRC, OP_CRC_LAST: crc_ff <= crc_next;
            default: ;
         endcase
      end
      if (load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/pat_section_parser.sv @@
// top level of the pat section parser
//
//   channel | direction | payload type  | handshake
//   req     | in        | psp_req_type  | req_valid / req_ready
//   rsp     | out       | psp_rsp_type  | rsp_valid / rsp_ready
//
// one byte beat is taken every cycle while the token queue has room; a byte
// that ends an entry, the section or a bad length is classified by the front
// and written to the queue as it is accepted, and the back then pops it and
// loads the result register that drives rsp
// the four-deep token queue and the result register let the output stall before
// req_ready drops
// reset (synchronous) empties the queue, drops any open section and clears
// rsp_valid; header and entry registers are loaded by the section start byte
`default_nettype none

module pat_section_parser
   import psp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire psp_req_type req_beat,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output psp_rsp_type      rsp_beat
);

   // classified bytes from the front end
   logic          front_valid, front_ready;
   psp_token_type front_tok;

   // queued bytes toward the back end
   logic          back_valid, back_ready;
   psp_token_type back_tok;

   // position tracking and byte classification
   psp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_beat  (req_beat),
      .tok_valid (front_valid),
      .tok_ready (front_ready),
      .tok       (front_tok)
   );

   // decouples front end from output stalls
   psp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_tok   (front_tok),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_tok    (back_tok)
   );

   // field capture and result generation
   psp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .tok_valid (back_valid),
      .tok_ready (back_ready),
      .tok       (back_tok),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_beat  (rsp_beat)
   );

endmodule

`default_nettype wire

@@ rtl/core/psp_checker.sv @@
// port level checks of the pat section parser and their bind
`default_nettype none

module psp_checker
   import psp_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire psp_rsp_type rsp_beat
);

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_beat))
      else $error("stalled result changed");

   // only summary and error results end a section
   a_done_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_beat.section_done |->
         rsp_beat.result_kind == KIND_SUMMARY || rsp_beat.result_kind == KIND_BADLEN)
      else $error("section_done on an entry result");

   // program number only on program entries
   a_prog_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_beat.result_kind != KIND_PROGRAM |->
         rsp_beat.prog_num == 16'd0)
      else $error("program number on a non-program result");

   // a length error comes before any entry or crc byte
   a_badlen_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_beat.result_kind == KIND_BADLEN |->
         rsp_beat.crc_value == 32'd0 && rsp_beat.entry_count == 10'd0 &&
         rsp_beat.stream_ident == 16'd0)
      else $error("length error carries section data");

endmodule

bind pat_section_parser psp_checker u_psp_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_beat  (rsp_beat)
);

`default_nettype wire
